// ----- sv/sorted_priority_queue_unit_macros.svh -----
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spq assertion failed");

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spq assertion failed");

`endif

// ----- sv/spq_pkg.sv -----
package spq_pkg;

    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_POP   = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic        [15:0] rank;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PUSH_RD,
        S_PUSH_WR,
        S_PUSH_NEW,
        S_POP_WAIT,
        S_QRY_RD,
        S_QRY_CHK,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        RES_OK,
        RES_EMPTY,
        RES_FULL,
        RES_POPPED,
        RES_FOUND
    } res_kind_t;

    typedef struct packed {
        logic      load;
        logic      idx_zero;
        logic      idx_tail;
        logic      idx_dec;
        logic      idx_inc;
        logic      rd_en;
        logic      rd_prev;
        logic      wr_en;
        logic      wr_new;
        logic      occ_inc;
        logic      pop_head;
        logic      res_en;
        res_kind_t res_kind;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       full;
        logic       empty;
        logic       idx_one;
        logic       idx_last;
        logic       rank_lt;
        logic       match;
        logic       out_free;
    } dp_status_t;

endpackage

// ----- sv/spq_ctrl.sv -----
module spq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  spq_pkg::dp_status_t sts,
    output spq_pkg::cmd_t      cmd
);
    import spq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.action)
                    ACT_PUSH:  state_next = sts.full ? S_DONE :
                                            (sts.empty ? S_PUSH_NEW : S_PUSH_RD);
                    ACT_POP:   state_next = sts.empty ? S_DONE : S_POP_WAIT;
                    ACT_QUERY: state_next = sts.empty ? S_DONE : S_QRY_RD;
                    default:   state_next = S_DONE;
                endcase
            end
            S_PUSH_RD:  state_next = S_PUSH_WR;
            S_PUSH_WR:
            begin
                if (sts.rank_lt)
                begin
                    state_next = S_DONE;
                end
                else if (sts.idx_one)
                begin
                    state_next = S_PUSH_NEW;
                end
                else
                begin
                    state_next = S_PUSH_RD;
                end
            end
            S_PUSH_NEW: state_next = S_DONE;
            S_POP_WAIT: state_next = S_DONE;
            S_QRY_RD:   state_next = S_QRY_CHK;
            S_QRY_CHK:
            begin
                if (sts.match || sts.idx_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_QRY_RD;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.res_kind = RES_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load     = in_valid;
                cmd.idx_zero = in_valid;
            end
            S_DECODE:
            begin
                case (sts.action)
                    ACT_PUSH:
                    begin
                        if (sts.full)
                        begin
                            cmd.res_en   = 1'b1;
                            cmd.res_kind = RES_FULL;
                        end
                        else
                        begin
                            cmd.idx_tail = 1'b1;
                        end
                    end
                    ACT_POP:
                    begin
                        if (sts.empty)
                        begin
                            cmd.res_en   = 1'b1;
                            cmd.res_kind = RES_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_en = 1'b1;
                        end
                    end
                    ACT_QUERY:
                    begin
                        cmd.res_en = sts.empty;
                    end
                    default:
                    begin
                        cmd.res_en = 1'b1;
                    end
                endcase
            end
            S_PUSH_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_prev = 1'b1;
            end
            S_PUSH_WR:
            begin
                cmd.wr_en = 1'b1;
                if (sts.rank_lt)
                begin
                    cmd.wr_new  = 1'b1;
                    cmd.occ_inc = 1'b1;
                    cmd.res_en  = 1'b1;
                end
                else
                begin
                    cmd.idx_dec = 1'b1;
                end
            end
            S_PUSH_NEW:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_new  = 1'b1;
                cmd.occ_inc = 1'b1;
                cmd.res_en  = 1'b1;
            end
            S_POP_WAIT:
            begin
                cmd.pop_head = 1'b1;
                cmd.res_en   = 1'b1;
                cmd.res_kind = RES_POPPED;
            end
            S_QRY_RD:
            begin
                cmd.rd_en = 1'b1;
            end
            S_QRY_CHK:
            begin
                if (sts.match)
                begin
                    cmd.res_en   = 1'b1;
                    cmd.res_kind = RES_FOUND;
                end
                else if (sts.idx_last)
                begin
                    cmd.res_en = 1'b1;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_DONE:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd.res_kind = RES_OK;
            end
        endcase
    end

endmodule

// ----- sv/spq_dp.sv -----
module spq_dp #(
    parameter int DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          action,
    input  logic signed [15:0]  coord_x,
    input  logic signed [15:0]  coord_y,
    input  logic [15:0]         rank,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  popped_x,
    output logic signed [15:0]  popped_y,
    output logic                found,
    output logic [1:0]          status,
    input  spq_pkg::cmd_t       cmd,
    output spq_pkg::dp_status_t sts
);
    import spq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);

    // circular store: logical slot 0 is the head
    entry_t mem [DEPTH];

    entry_t              item_reg;
    logic [1:0]          action_reg;
    entry_t              rdata_reg;
    logic [AW-1:0]       head_reg;
    logic [AW-1:0]       head_next;
    logic [OW-1:0]       occ_reg;
    logic [OW-1:0]       occ_next;
    logic [AW-1:0]       idx_reg;
    logic [AW-1:0]       idx_next;
    logic [AW-1:0]       idx_prev;
    logic [AW-1:0]       raddr;
    logic [AW-1:0]       waddr;
    entry_t              wdata;
    logic signed [15:0]  res_x_reg;
    logic signed [15:0]  res_y_reg;
    logic                res_found_reg;
    logic [1:0]          res_status_reg;
    logic signed [15:0]  res_x_next;
    logic signed [15:0]  res_y_next;
    logic                res_found_next;
    logic [1:0]          res_status_next;
    logic signed [15:0]  out_x_reg;
    logic signed [15:0]  out_y_reg;
    logic                out_found_reg;
    logic [1:0]          out_status_reg;
    logic                out_valid_reg;
    logic                out_valid_next;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [AW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= DEPTH_W)
        begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    assign idx_prev = idx_reg - AW'(1);
    assign raddr    = phys(head_reg, cmd.rd_prev ? idx_prev : idx_reg);
    assign waddr    = phys(head_reg, idx_reg);
    assign wdata    = cmd.wr_new ? item_reg : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg   <= '{x: coord_x, y: coord_y, rank: rank};
            action_reg <= action;
        end
        if (cmd.res_en)
        begin
            res_x_reg      <= res_x_next;
            res_y_reg      <= res_y_next;
            res_found_reg  <= res_found_next;
            res_status_reg <= res_status_next;
        end
        if (cmd.out_load)
        begin
            out_x_reg      <= res_x_reg;
            out_y_reg      <= res_y_reg;
            out_found_reg  <= res_found_reg;
            out_status_reg <= res_status_reg;
        end
    end

    always_comb
    begin
        res_x_next      = '0;
        res_y_next      = '0;
        res_found_next  = 1'b0;
        res_status_next = ST_OK;
        case (cmd.res_kind)
            RES_EMPTY:  res_status_next = ST_EMPTY;
            RES_FULL:   res_status_next = ST_FULL;
            RES_POPPED:
            begin
                res_x_next = rdata_reg.x;
                res_y_next = rdata_reg.y;
            end
            RES_FOUND:  res_found_next = 1'b1;
            default:    res_status_next = ST_OK;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_zero)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_tail)
        begin
            idx_next = occ_reg[AW-1:0];
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_prev;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + AW'(1);
        end

        head_next = cmd.pop_head ? phys(head_reg, AW'(1)) : head_reg;

        occ_next = occ_reg;
        if (cmd.occ_inc)
        begin
            occ_next = occ_reg + OW'(1);
        end
        else if (cmd.pop_head)
        begin
            occ_next = occ_reg - OW'(1);
        end

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            occ_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.action   = action_reg;
    assign sts.full     = (occ_reg == OW'(DEPTH));
    assign sts.empty    = (occ_reg == '0);
    assign sts.idx_one  = (idx_reg == AW'(1));
    assign sts.idx_last = ((OW'(idx_reg) + OW'(1)) == occ_reg);
    assign sts.rank_lt  = (rdata_reg.rank < item_reg.rank);
    assign sts.match    = (rdata_reg.x == item_reg.x) && (rdata_reg.y == item_reg.y);
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign popped_x  = out_x_reg;
    assign popped_y  = out_y_reg;
    assign found     = out_found_reg;
    assign status    = out_status_reg;

endmodule

// ----- sv/sorted_priority_queue_unit.sv -----
// channel | handshake            | words
// --------+----------------------+-------------------------------------
// in      | in_valid / in_stall  | action, coord_x, coord_y, rank
// out     | out_valid / out_stall| popped_x, popped_y, found, status
//
// One word at a time. A pop reads and retires the head; a query checks entries
// from the head to a match or the last one; a push moves entries back from the
// tail until one ranks below it, then writes in behind (at the head if none does).
// The store has one read and one write port; a step has a read and a check state.
// Reset clears occupancy, head, index and out_valid; no clearing pass over the store.
// A result held by out_stall does not block the next word from being taken.
module sorted_priority_queue_unit #(
    parameter int DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic signed [15:0] coord_x,
    input  logic signed [15:0] coord_y,
    input  logic [15:0]        rank,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] popped_x,
    output logic signed [15:0] popped_y,
    output logic               found,
    output logic [1:0]         status
);
    import spq_pkg::*;

    cmd_t       cmd;
    dp_status_t sts;

    spq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    spq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .action    (action),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .rank      (rank),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .popped_x  (popped_x),
        .popped_y  (popped_y),
        .found     (found),
        .status    (status),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ----- sv/spq_checker.sv -----
`include "sorted_priority_queue_unit_macros.svh"

module spq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] popped_x,
    input logic signed [15:0] popped_y,
    input logic               found,
    input logic [1:0]         status
);
    import spq_pkg::*;

    `SPQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `SPQ_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
        $stable(popped_x) && $stable(popped_y) && $stable(found) && $stable(status))
    `SPQ_ASSERT_NOW(a_found_clean, out_valid && found,
        status == ST_OK && popped_x == 16'sd0 && popped_y == 16'sd0)
    `SPQ_ASSERT_NOW(a_error_clean, out_valid && status != ST_OK,
        !found && popped_x == 16'sd0 && popped_y == 16'sd0)
    `SPQ_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (.*);
